// File: rtl/core/lsb_stego_embedder_defines.svh
// Assertion macros used by the checker file.
`ifndef LSB_STEGO_EMBEDDER_DEFINES_SVH
`define LSB_STEGO_EMBEDDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define LSBSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define LSBSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/lsbse_pkg.sv
package lsbse_pkg;

	localparam int unsigned POS_W = 36;

	// Frame layout, byte positions
	localparam logic [POS_W-1:0] HEADER_BYTES = 36'd54;
	localparam logic [POS_W-1:0] EXT_LEN_OFF  = 36'd8;
	localparam logic [POS_W-1:0] EXT_CHR_OFF  = 36'd40;
	localparam logic [POS_W-1:0] SIZE_OFF     = 36'd72;
	localparam logic [POS_W-1:0] PAYLOAD_OFF  = 36'd104;
	localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

	// Register reset values
	localparam logic [7:0]  MAGIC_RST   = 8'd0;
	localparam logic [3:0]  EXT_LEN_RST = 4'd4;
	localparam logic [31:0] EXT_CHR_RST = 32'd0;
	localparam logic [31:0] SIZE_RST    = 32'd0;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MAGIC   = 2'd0,
		REG_EXT_LEN = 2'd1,
		REG_EXT_CHR = 2'd2,
		REG_SIZE    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  magic_char;
		logic [3:0]  ext_length;
		logic [31:0] ext_chars;
		logic [31:0] secret_size;
	} cfg_t;

	// Per-beat decision from the frame decoder
	typedef struct packed {
		logic in_frame; // LSB is replaced
		logic lsb;      // bit to put in the LSB
		logic latch;    // secret byte taken on this beat
		logic done;     // last frame bit
	} frame_res_t;

endpackage

// File: rtl/core/lsb_stego_embedder.sv
// LSB steganography embedder.
// Input channel (in_valid / in_stall) carries one cover image byte and the
// current secret byte per beat; output channel (out_valid / out_stall)
// returns the stego byte with secret_taken and embed_done flags.
// A beat moves when valid is high and stall is low at a rising clk edge.
// A beat goes from the input register to the result register. Throughput:
// one beat per cycle while out_stall is low, set by the single
// decode-and-replace stage between the two registers.
// When the receiver stalls, the result register holds and one further
// beat is kept in the input register; in_stall rises once both are full.
// Configuration: cfg_wr_en with cfg_index / cfg_data writes one register;
// any write restarts the frame at byte position zero. Write only while
// the block is idle.
// Reset (arst_n low) empties both stages, clears the byte position and the
// secret shift register and returns the registers to their defaults.
module lsb_stego_embedder import lsbse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  image_byte,
	input  logic [7:0]  secret_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  stego_byte,
	output logic        secret_taken,
	output logic        embed_done,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t             cfg_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       shift_q;
	logic             valid_s1;
	logic [7:0]       image_s1;
	logic [7:0]       secret_s1;
	logic             out_valid_q;
	logic [7:0]       stego_q;
	logic             taken_q;
	logic             done_q;
	logic             accept;
	logic             adv;
	frame_res_t       fres;
	cfg_reg_t         widx;

	// Handshake
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign widx     = cfg_reg_t'(cfg_index);

	// Frame decode
	lsbse_frame u_frame (
		.pos          (pos_q),
		.cfg          (cfg_q),
		.secret_shift (shift_q),
		.secret_byte  (secret_s1),
		.res          (fres)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_char  <= MAGIC_RST;
			cfg_q.ext_length  <= EXT_LEN_RST;
			cfg_q.ext_chars   <= EXT_CHR_RST;
			cfg_q.secret_size <= SIZE_RST;
		end else if (cfg_wr_en) begin
			unique case (widx)
				REG_MAGIC:   cfg_q.magic_char  <= cfg_data[7:0];
				REG_EXT_LEN: cfg_q.ext_length  <= cfg_data[3:0];
				REG_EXT_CHR: cfg_q.ext_chars   <= cfg_data;
				REG_SIZE:    cfg_q.secret_size <= cfg_data;
			endcase
		end
	end

	// Byte position and secret shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			shift_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				pos_q <= '0;
			end else if (adv && (pos_q != POS_MAX)) begin
				pos_q <= pos_q + 36'd1;
			end
			if (adv && fres.latch) begin
				shift_q <= secret_s1;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			image_s1  <= image_byte;
			secret_s1 <= secret_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stego_q <= fres.in_frame ? {image_s1[7:1], fres.lsb} : image_s1;
			taken_q <= fres.latch;
			done_q  <= fres.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign stego_byte   = stego_q;
	assign secret_taken = taken_q;
	assign embed_done   = done_q;

endmodule

// File: rtl/core/lsbse_frame.sv
module lsbse_frame import lsbse_pkg::*; (
	input  logic [POS_W-1:0] pos,
	input  cfg_t             cfg,
	input  logic [7:0]       secret_shift,
	input  logic [7:0]       secret_byte,
	output frame_res_t       res
);

	logic [POS_W-1:0] off;
	logic [POS_W-1:0] d_len;
	logic [POS_W-1:0] d_chr;
	logic [POS_W-1:0] d_size;
	logic [POS_W-1:0] payload_end;
	logic [POS_W-1:0] last_off;
	logic [4:0]       j_len;
	logic [4:0]       j_chr;
	logic [4:0]       j_size;
	logic [2:0]       q;
	logic [31:0]      len32;
	logic             chr_en;

	// Field offsets from the end of the header
	assign off     = pos - HEADER_BYTES;
	assign d_len   = off - EXT_LEN_OFF;
	assign d_chr   = off - EXT_CHR_OFF;
	assign d_size  = off - SIZE_OFF;
	assign j_len   = d_len[4:0];
	assign j_chr   = d_chr[4:0];
	assign j_size  = d_size[4:0];
	assign q       = off[2:0];
	assign len32   = {28'd0, cfg.ext_length};

	// Extension character sent only below the given length
	assign chr_en  = {2'b00, j_chr[4:3]} < cfg.ext_length;

	// Payload end and the offset of the final frame bit
	assign payload_end = PAYLOAD_OFF + {1'b0, cfg.secret_size, 3'b000};
	assign last_off    = (cfg.secret_size == 32'd0) ? (PAYLOAD_OFF - 36'd1)
	                                                : (payload_end - 36'd1);

	always_comb begin
		res = '0;
		if (pos >= HEADER_BYTES) begin
			res.done = (off == last_off);
			priority if (off < EXT_LEN_OFF) begin
				res.in_frame = 1'b1;
				res.lsb      = cfg.magic_char[~q];
			end else if (off < EXT_CHR_OFF) begin
				res.in_frame = 1'b1;
				res.lsb      = len32[~j_len];
			end else if (off < SIZE_OFF) begin
				res.in_frame = 1'b1;
				res.lsb      = chr_en & cfg.ext_chars[~j_chr];
			end else if (off < PAYLOAD_OFF) begin
				res.in_frame = 1'b1;
				res.lsb      = cfg.secret_size[~j_size];
			end else if (off < payload_end) begin
				// One secret byte per eight image bytes, MSB first
				res.in_frame = 1'b1;
				res.latch    = (q == 3'd0);
				res.lsb      = (q == 3'd0) ? secret_byte[7] : secret_shift[~q];
			end else begin
				res.in_frame = 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/lsbse_checker.sv
`include "lsb_stego_embedder_defines.svh"

module lsbse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  stego_byte,
	input logic        secret_taken,
	input logic        embed_done
);

	// A stalled result beat stays valid
	`LSBSE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled beat dropped")

	// A stalled result beat keeps its payload
	`LSBSE_ASSERT_NXT(a_out_stable, out_valid && out_stall,
		$stable(stego_byte) && $stable(secret_taken) && $stable(embed_done),
		"stalled payload changed")

	// A secret byte is never latched on the final frame bit
	`LSBSE_ASSERT_IMP(a_flags_excl, out_valid, !(secret_taken && embed_done),
		"taken and done together")

	// The frame end is flagged once, never on the following beat
	`LSBSE_ASSERT_NXT(a_done_once, out_valid && !out_stall && embed_done,
		!(out_valid && embed_done), "frame end flagged twice")

endmodule

bind lsb_stego_embedder lsbse_checker u_lsbse_checker (.*);
